// ----- rtl/mbrb_pkg.sv -----
// ============================================================================
// mbrb_pkg: shared types and constants for the rotate blitter
// Register indexes, field widths and the two output colors.
// ============================================================================
package mbrb_pkg;

    localparam int REG_W        = 11;
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 19;
    localparam int COLOR_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int PIX_PER_BYTE = 8;
    localparam int SEL_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    localparam logic [REG_W-1:0] SOURCE_WIDTH_RESET  = 11'd512;
    localparam logic [REG_W-1:0] SOURCE_HEIGHT_RESET = 11'd342;

    localparam logic [COLOR_W-1:0] COLOR_SET   = 16'h0000;
    localparam logic [COLOR_W-1:0] COLOR_CLEAR = 16'hFFFF;

    typedef logic [PIX_PER_BYTE-1:0] pix_mask_t;

endpackage

// ----- rtl/mono_bitmap_rotate_blit_top.sv -----
// ============================================================================
// mono_bitmap_rotate_blit_top: 1bpp bitmap rotate-and-center blitter
// Bytes turn into rotated RGB565 framebuffer writes, one per cycle unless stalled.
// ============================================================================
// Path: a byte accepted into the input register moves to the pixel mask
//   register, and each kept pixel then to the output register.
// Throughput: one pixel beat per cycle while out_ready allows; a byte holds the
//   emitter until its on-panel pixels (up to 8) are out, or passes if it has none.
// Reset: rst_n clears counters, pipeline valids and loads 512 x 342 geometry.
// ============================================================================
module mono_bitmap_rotate_blit_top
    import mbrb_pkg::*;
#(
    parameter int PANEL_WIDTH    = 480,
    parameter int PANEL_HEIGHT   = 640,
    parameter int MAX_SOURCE_DIM = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // source byte channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    pixel_byte,
    // pixel result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    fb_address,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic                 last_of_byte,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    // Largest usable dimension: clamp limit, bounded by what the register holds.
    localparam int DIM_MAX    = (MAX_SOURCE_DIM < 2047) ? MAX_SOURCE_DIM : 2047;
    localparam int ROW_W      = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int STRIDE_MAX = (DIM_MAX + 7) / 8;
    localparam int COL_W      = (STRIDE_MAX > 1) ? $clog2(STRIDE_MAX) : 1;
    localparam int STR_W      = REG_W - 2;
    localparam int CW         = REG_W + 1;
    // Signed width for panel coordinates, with headroom for negative offsets.
    localparam int SW = $clog2(PANEL_WIDTH + PANEL_HEIGHT + 2 * DIM_MAX + 16) + 2;

    localparam logic signed [SW-1:0] PW_S   = SW'(PANEL_WIDTH);
    localparam logic signed [SW-1:0] PH_S   = SW'(PANEL_HEIGHT);
    localparam logic signed [SW-1:0] ONE_S  = SW'(1);
    localparam logic signed [SW-1:0] ZERO_S = SW'(0);
    localparam logic [ADDR_W-1:0]    PW_A   = ADDR_W'(PANEL_WIDTH);
    localparam logic [REG_W-1:0]     DIM_MAX_R = REG_W'(DIM_MAX);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken, unknown index dropped
    // ------------------------------------------------------------------
    logic [REG_W-1:0] src_w_reg, src_w_next;
    logic [REG_W-1:0] src_h_reg, src_h_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_SOURCE_WIDTH)
            begin
                src_w_next = cfg_data;
            end
            if (cfg_index == REG_SOURCE_HEIGHT)
            begin
                src_h_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SOURCE_WIDTH_RESET;
            src_h_reg <= SOURCE_HEIGHT_RESET;
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
        end
    end

    // Clamp: zero acts as one, anything past the limit acts as the limit.
    logic [REG_W-1:0] w_eff;
    logic [REG_W-1:0] h_eff;
    logic [STR_W-1:0] stride;
    logic [REG_W:0]   w_plus7;

    always_comb
    begin
        priority if (src_w_reg == '0)
            w_eff = REG_W'(1);
        else if (int'(src_w_reg) > MAX_SOURCE_DIM)
            w_eff = DIM_MAX_R;
        else
            w_eff = src_w_reg;

        priority if (src_h_reg == '0)
            h_eff = REG_W'(1);
        else if (int'(src_h_reg) > MAX_SOURCE_DIM)
            h_eff = DIM_MAX_R;
        else
            h_eff = src_h_reg;
    end

    // Row stride in bytes, rounded up.
    assign w_plus7 = {1'b0, w_eff} + (REG_W+1)'(7);
    assign stride  = w_plus7[REG_W:3];

    // ------------------------------------------------------------------
    // Source position counters, advanced per accepted byte
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_eff;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W:0]   row_p1;
    logic [COL_W:0]   col_p1;
    logic             col_wrap;
    logic             in_fire;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        // Normalize first: a column past the stride moves to the next row, a
        // row past the height wraps (only seen after a geometry change).
        col_wrap = CW'(col_reg) >= CW'(stride);
        row_inc  = col_wrap ? ({1'b0, row_reg} + (ROW_W+1)'(1)) : {1'b0, row_reg};
        row_eff  = (CW'(row_inc) >= CW'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
        col_eff  = col_wrap ? '0 : col_reg;

        col_p1 = {1'b0, col_eff} + (COL_W+1)'(1);
        row_p1 = {1'b0, row_eff} + (ROW_W+1)'(1);

        row_next = row_reg;
        col_next = col_reg;
        if (in_fire)
        begin
            if (CW'(col_p1) >= CW'(stride))
            begin
                col_next = '0;
                row_next = (CW'(row_p1) >= CW'(h_eff)) ? '0 : row_p1[ROW_W-1:0];
            end
            else
            begin
                col_next = col_p1[COL_W-1:0];
                row_next = row_eff;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: byte with its resolved row and column
    // ------------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_adv;

    assign in_ready      = !s1_valid_reg || s1_adv;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= pixel_byte;
            s1_row_reg  <= row_eff;
            s1_col_reg  <= col_eff;
        end
    end

    // ------------------------------------------------------------------
    // Placement: rotated column dx, top panel row dy0, keep mask, base address
    // ------------------------------------------------------------------
    logic signed [SW-1:0] h_s, w_s, row_s, col8_s;
    logic signed [SW-1:0] diff_x, diff_y, diff_x_adj, diff_y_adj;
    logic signed [SW-1:0] off_x, off_y, dx, dy0;
    logic signed [SW-1:0] lx_i, dy_i;
    logic                 dx_ok;
    pix_mask_t            keep;
    logic [ADDR_W-1:0]    dy0_u, dx_u, base_addr;
    logic [2*ADDR_W-1:0]  base_prod;

    always_comb
    begin
        h_s    = signed'(SW'(h_eff));
        w_s    = signed'(SW'(w_eff));
        row_s  = signed'(SW'(s1_row_reg));
        col8_s = signed'(SW'({s1_col_reg, 3'b000}));

        // Halve toward zero: bias negative values by one before the shift.
        diff_x     = PW_S - h_s;
        diff_y     = PH_S - w_s;
        diff_x_adj = diff_x + (diff_x[SW-1] ? ONE_S : ZERO_S);
        diff_y_adj = diff_y + (diff_y[SW-1] ? ONE_S : ZERO_S);
        off_x      = diff_x_adj >>> 1;
        off_y      = diff_y_adj >>> 1;

        dx    = off_x + h_s - ONE_S - row_s;
        dy0   = off_y + col8_s;
        dx_ok = (dx >= ZERO_S) && (dx < PW_S);

        keep = '0;
        for (int i = 0; i < PIX_PER_BYTE; i++)
        begin
            lx_i    = col8_s + signed'(SW'(i));
            dy_i    = dy0 + signed'(SW'(i));
            keep[i] = dx_ok && (lx_i < w_s) && (dy_i >= ZERO_S) && (dy_i < PH_S);
        end

        // Address arithmetic is modulo 2^ADDR_W, so a negative dy0 is fine.
        dy0_u     = ADDR_W'(dy0);
        dx_u      = ADDR_W'(dx);
        base_prod = {{ADDR_W{1'b0}}, dy0_u} * {{ADDR_W{1'b0}}, PW_A};
        base_addr = base_prod[ADDR_W-1:0] + dx_u;
    end

    // ------------------------------------------------------------------
    // Emitter: walk the keep mask in increasing lx; while out_ready allows, one pixel a cycle
    // ------------------------------------------------------------------
    pix_mask_t          em_mask_reg, em_mask_next;
    logic [BYTE_W-1:0]  em_byte_reg;
    logic [ADDR_W-1:0]  em_base_reg;
    logic [SEL_W-1:0]   em_sel;
    pix_mask_t          em_rest;
    logic               em_fire;
    logic               em_last;

    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  fb_address_reg;
    logic [COLOR_W-1:0] pixel_color_reg;
    logic               last_reg;

    always_comb
    begin
        em_sel = '0;
        for (int i = PIX_PER_BYTE - 1; i >= 0; i--)
        begin
            if (em_mask_reg[i])
            begin
                em_sel = SEL_W'(i);
            end
        end
        em_rest         = em_mask_reg;
        em_rest[em_sel] = 1'b0;
    end

    assign em_last = (em_rest == '0);
    assign em_fire = (em_mask_reg != '0) && (!out_valid_reg || out_ready);
    // Hand the next byte over once the current one has nothing left to emit.
    assign s1_adv  = s1_valid_reg && ((em_mask_reg == '0) || (em_fire && em_last));

    always_comb
    begin
        em_mask_next = em_mask_reg;
        if (s1_adv)
        begin
            em_mask_next = keep;
        end
        else if (em_fire)
        begin
            em_mask_next = em_rest;
        end
    end

    assign out_valid_next = em_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_mask_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            em_mask_reg   <= em_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            em_byte_reg <= s1_byte_reg;
            em_base_reg <= base_addr;
        end
        if (em_fire)
        begin
            // Pixel lx = col*8 + sel sits at bit 7 - sel of the byte.
            fb_address_reg  <= em_base_reg + ADDR_W'(PW_A * ADDR_W'(em_sel));
            pixel_color_reg <= em_byte_reg[~em_sel] ? COLOR_SET : COLOR_CLEAR;
            last_reg        <= em_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fb_address   = fb_address_reg;
    assign pixel_color  = pixel_color_reg;
    assign last_of_byte = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        em_fire |=> out_valid)
        else $error("emitted pixel did not reach the output register");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (em_fire && em_last && !s1_adv) |=> (em_mask_reg == '0))
        else $error("pixel mask not empty after last pixel of byte");

    a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_adv && (em_mask_reg != '0)) |=> ((em_mask_reg & ~$past(em_mask_reg)) == '0))
        else $error("pixel mask gained bits without a new byte");

    a_adv_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (em_mask_reg != '0)) |-> (em_fire && em_last))
        else $error("byte handed over while pixels still pending");

endmodule
